>>> rtl/core/lif_pkg.sv
`default_nettype none

package lif_pkg;

	// Field widths
	localparam int VOLT_W  = 32;
	localparam int THR_W   = 31;
	localparam int LEAK_W  = 16;
	localparam int REFR_W  = 8;
	localparam int STEP_W  = 16;
	localparam int RATE_W  = 16;
	localparam int DRIVE_W = 48;
	localparam int FCNT_W  = 16;
	localparam int CFG_W   = 31;
	localparam int CFG_IDX_W = 3;

	// Operation codes carried by each input beat
	typedef enum logic [2:0] {
		OP_TICK      = 3'd0,
		OP_PULSE     = 3'd1,
		OP_SET_VOLT  = 3'd2,
		OP_MARK_FIRE = 3'd3,
		OP_ADAPT     = 3'd4,
		OP_CLR_COUNT = 3'd5,
		OP_RESET     = 3'd6
	} op_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEAK_FACTOR  = 3'd0,
		REG_REFR_TICKS   = 3'd1,
		REG_THR_STEP     = 3'd2,
		REG_THR_FLOOR    = 3'd3,
		REG_THR_CEILING  = 3'd4,
		REG_INIT_THR     = 3'd5,
		REG_TARGET_RATE  = 3'd6,
		REG_ADAPTS       = 3'd7
	} cfg_reg_t;

	// Register reset values
	localparam logic [LEAK_W-1:0] LEAK_RST    = 16'd62259;
	localparam logic [REFR_W-1:0] REFR_RST    = 8'd2;
	localparam logic [STEP_W-1:0] STEP_RST    = 16'd655;
	localparam logic [THR_W-1:0]  FLOOR_RST   = 31'd6554;
	localparam logic [THR_W-1:0]  CEILING_RST = 31'd655360;
	localparam logic [THR_W-1:0]  INIT_THR_RST = 31'd65536;
	localparam logic [RATE_W-1:0] RATE_RST    = 16'd5;

endpackage

`default_nettype wire

>>> rtl/core/lif_if.sv
`default_nettype none

// Input channel: one operation per beat
interface lif_in_if
	import lif_pkg::*;
();
	logic                     valid;
	logic                     ready;
	op_t                      operation;
	logic signed [VOLT_W-1:0] amount;

	modport source (output valid, output operation, output amount, input ready);
	modport sink (input valid, input operation, input amount, output ready);
endinterface

// Result channel: neuron state after each operation
interface lif_out_if
	import lif_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic                     spike;
	logic signed [VOLT_W-1:0] voltage_out;
	logic [THR_W-1:0]         threshold_out;
	logic [FCNT_W-1:0]        fire_count_out;
	logic [DRIVE_W-1:0]       drive_out;

	modport source (output valid, output spike, output voltage_out, output threshold_out,
		output fire_count_out, output drive_out, input ready);
	modport sink (input valid, input spike, input voltage_out, input threshold_out,
		input fire_count_out, input drive_out, output ready);
endinterface

`default_nettype wire

>>> rtl/core/leaky_integrate_fire_neuron.sv
`default_nettype none

// Leaky integrate-and-fire neuron with adaptive threshold. One operation beat is taken
// every clock cycle while results keep draining. An accepted operation waits in the input
// register until the result register is free or being taken, and its result is then
// loaded into the result register. The cycle time is set by the tick path: a 32x17 leak
// multiply and the saturating drive adder, chosen between in one pass on the state
// registers. A write to initial_threshold also reloads the live threshold. The user must
// write configuration only while no operation is in flight; the block itself does not enforce this.
module leaky_integrate_fire_neuron
	import lif_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  wire                    clk,
	input  wire                    arst_n,
	lif_in_if.sink                 item,
	lif_out_if.source              result,
	input  wire                    cfg_we,
	input  wire [CFG_IDX_W-1:0]    cfg_index,
	input  wire [CFG_W-1:0]        cfg_data
);

	localparam int CW = COUNT_WIDTH;

	// Configuration registers
	logic [LEAK_W-1:0] leak_q;
	logic [REFR_W-1:0] refr_ticks_q;
	logic [STEP_W-1:0] step_q;
	logic [THR_W-1:0]  floor_q;
	logic [THR_W-1:0]  ceiling_q;
	logic [RATE_W-1:0] target_q;
	logic              adapts_q;

	// Neuron state
	logic signed [VOLT_W-1:0] volt_q;
	logic [THR_W-1:0]         thr_q;
	logic [CW-1:0]            cnt_q;
	logic [DRIVE_W-1:0]       drive_q;
	logic [REFR_W-1:0]        refr_q;
	logic                     spike_q;

	// Pipeline
	logic                     valid_s1;
	op_t                      op_s1;
	logic signed [VOLT_W-1:0] amount_s1;
	logic                     valid_s2;
	logic                     advance;

	// Next state
	logic signed [VOLT_W-1:0] volt_n;
	logic [THR_W-1:0]         thr_n;
	logic [CW-1:0]            cnt_n;
	logic [DRIVE_W-1:0]       drive_n;
	logic [REFR_W-1:0]        refr_n;
	logic                     spike_n;

	// Datapath terms
	logic [CW-1:0]            cnt_inc;
	logic signed [VOLT_W:0]   diff;
	logic signed [VOLT_W:0]   psum;
	logic signed [48:0]       prod;
	logic [DRIVE_W:0]         drive_sum;
	logic [32:0]              cnt_w;
	logic [32:0]              tgt_w;
	logic signed [33:0]       t_step;
	logic signed [33:0]       t_floor;
	logic signed [33:0]       t_clamp;

	// Saturate a counter value onto the 16-bit result field
	function automatic logic [FCNT_W-1:0] fcnt_sat_n(input logic [CW-1:0] c);
		logic [32:0] w;
		w = 33'(c);
		return (w > 33'(FCNT_W'('1))) ? {FCNT_W{1'b1}} : w[FCNT_W-1:0];
	endfunction

	// Handshake: stage 1 moves on whenever the result register is free or being taken
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1     <= item.operation;
			amount_s1 <= item.amount;
		end
	end

	// Shared arithmetic
	assign cnt_inc   = (&cnt_q) ? cnt_q : cnt_q + CW'(1);
	assign diff      = (VOLT_W+1)'(volt_q) - (VOLT_W+1)'({1'b0, thr_q});
	assign psum      = (VOLT_W+1)'(volt_q) + (VOLT_W+1)'(amount_s1);
	assign prod      = volt_q * $signed({1'b0, leak_q});
	assign drive_sum = (DRIVE_W+1)'(drive_q) + (DRIVE_W+1)'(volt_q[VOLT_W-2:0]);
	assign cnt_w     = 33'(cnt_q);
	assign tgt_w     = 33'(target_q);

	// Adaptation: one step toward the target, then floor, then ceiling
	always_comb begin
		if (cnt_w > tgt_w) begin
			t_step = $signed({3'b000, thr_q}) + $signed({18'd0, step_q});
		end else if (cnt_w < tgt_w) begin
			t_step = $signed({3'b000, thr_q}) - $signed({18'd0, step_q});
		end else begin
			t_step = $signed({3'b000, thr_q});
		end
		t_floor = (t_step < $signed({3'b000, floor_q})) ? $signed({3'b000, floor_q}) : t_step;
		t_clamp = (t_floor > $signed({3'b000, ceiling_q})) ? $signed({3'b000, ceiling_q})
			: t_floor;
	end

	// Operation decode
	always_comb begin
		volt_n  = volt_q;
		thr_n   = thr_q;
		cnt_n   = cnt_q;
		drive_n = drive_q;
		refr_n  = refr_q;
		spike_n = spike_q;
		unique case (op_s1)
			OP_TICK: begin
				if (refr_q != '0) begin
					refr_n  = refr_q - REFR_W'(1);
					spike_n = 1'b0;
				end else if (!diff[VOLT_W]) begin
					// at or above threshold: fire
					spike_n = 1'b1;
					cnt_n   = cnt_inc;
					drive_n = drive_sum[DRIVE_W] ? {DRIVE_W{1'b1}} : drive_sum[DRIVE_W-1:0];
					volt_n  = diff[VOLT_W-1:0];
					refr_n  = refr_ticks_q;
				end else begin
					// leak, arithmetic shift floors toward minus infinity
					spike_n = 1'b0;
					volt_n  = prod[LEAK_W+VOLT_W-1:LEAK_W];
				end
			end
			OP_PULSE: begin
				if (psum[VOLT_W] != psum[VOLT_W-1]) begin
					volt_n = psum[VOLT_W] ? {1'b1, {(VOLT_W-1){1'b0}}}
						: {1'b0, {(VOLT_W-1){1'b1}}};
				end else begin
					volt_n = psum[VOLT_W-1:0];
				end
			end
			OP_SET_VOLT: begin
				volt_n = amount_s1;
			end
			OP_MARK_FIRE: begin
				spike_n = 1'b1;
				cnt_n   = cnt_inc;
			end
			OP_ADAPT: begin
				if (adapts_q) begin
					thr_n = t_clamp[THR_W-1:0];
				end
			end
			OP_CLR_COUNT: begin
				cnt_n = '0;
			end
			OP_RESET: begin
				volt_n  = '0;
				drive_n = '0;
				spike_n = 1'b0;
				refr_n  = '0;
			end
			default: begin
			end
		endcase
	end

	// Configuration and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leak_q       <= LEAK_RST;
			refr_ticks_q <= REFR_RST;
			step_q       <= STEP_RST;
			floor_q      <= FLOOR_RST;
			ceiling_q    <= CEILING_RST;
			target_q     <= RATE_RST;
			adapts_q     <= 1'b1;
			volt_q       <= '0;
			thr_q        <= INIT_THR_RST;
			cnt_q        <= '0;
			drive_q      <= '0;
			refr_q       <= '0;
			spike_q      <= 1'b0;
		end else begin
			if (advance) begin
				volt_q  <= volt_n;
				cnt_q   <= cnt_n;
				drive_q <= drive_n;
				refr_q  <= refr_n;
				spike_q <= spike_n;
			end
			// a write of initial_threshold reloads the live threshold
			if (cfg_we && cfg_reg_t'(cfg_index) == REG_INIT_THR) begin
				thr_q <= cfg_data[THR_W-1:0];
			end else if (advance) begin
				thr_q <= thr_n;
			end
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_LEAK_FACTOR: leak_q       <= cfg_data[LEAK_W-1:0];
					REG_REFR_TICKS:  refr_ticks_q <= cfg_data[REFR_W-1:0];
					REG_THR_STEP:    step_q       <= cfg_data[STEP_W-1:0];
					REG_THR_FLOOR:   floor_q      <= cfg_data[THR_W-1:0];
					REG_THR_CEILING: ceiling_q    <= cfg_data[THR_W-1:0];
					REG_INIT_THR: begin
						// only the live threshold above
					end
					REG_TARGET_RATE: target_q     <= cfg_data[RATE_W-1:0];
					REG_ADAPTS:      adapts_q     <= cfg_data[0];
				endcase
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (advance) begin
			result.spike          <= spike_n;
			result.voltage_out    <= volt_n;
			result.threshold_out  <= thr_n;
			result.fire_count_out <= fcnt_sat_n(cnt_n);
			result.drive_out      <= drive_n;
		end
	end

	assign result.valid = valid_s2;

`ifndef SYNTH
	// An empty input register never holds off the source
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> item.ready)
		else $error("input stalled with empty stage");

	// A tick in the refractory period counts down and stays silent
	a_refractory: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == OP_TICK && refr_q != '0 && !cfg_we
		|=> !spike_q && refr_q == REFR_W'($past(refr_q) - REFR_W'(1)))
		else $error("refractory tick misbehaved");

	// Enabled adaptation never leaves the threshold above the ceiling
	a_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == OP_ADAPT && adapts_q && !cfg_we |=> thr_q <= ceiling_q)
		else $error("threshold above ceiling after adapt");

	// Only a clear lowers the spike count
	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && op_s1 == OP_CLR_COUNT) |=> cnt_q >= $past(cnt_q))
		else $error("spike count fell without a clear");

	// The live counter and the reported count agree whenever a result is loaded
	a_count_report: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result.fire_count_out == fcnt_sat_n(cnt_q))
		else $error("reported count differs from counter");
`endif

endmodule

`default_nettype wire

>>> dv/leaky_integrate_fire_neuron_test.sv
`default_nettype none

module leaky_integrate_fire_neuron_test;
	import lif_pkg::*;

	localparam logic [2:0] OP_SPARE_CODE = 3'd7;   // decodes to no operation
	localparam int LEAK_SHIFT = 16;
	localparam longint VOLT_MAX = 64'sd2147483647;
	localparam longint VOLT_MIN = -64'sd2147483648;
	localparam longint DRIVE_FULL = 64'sh0000_FFFF_FFFF_FFFF;
	localparam logic [FCNT_W-1:0] COUNT_FULL = '1;
	localparam int QUEUE_AHEAD = 64;
	localparam int QUIET_LIMIT = 2000;
	localparam int PRINT_LIMIT = 200;
	localparam int FIRE_TICKS = 40;   // back-to-back spikes at full-scale voltage

	typedef struct {
		op_t                      op;
		logic signed [VOLT_W-1:0] amount;
	} neuron_cmd_t;

	typedef struct {
		logic                     spike;
		logic signed [VOLT_W-1:0] volt;
		logic [THR_W-1:0]         thr;
		logic [FCNT_W-1:0]        count;
		logic [DRIVE_W-1:0]       drive;
	} neuron_view_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	lif_in_if  item_ch ();
	lif_out_if result_ch ();

	leaky_integrate_fire_neuron uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Predicted neuron state and its register copy
	logic signed [VOLT_W-1:0] volt_q;
	logic [THR_W-1:0]         thr_q;
	logic [FCNT_W-1:0]        count_q;
	logic [DRIVE_W-1:0]       drive_q;
	logic [REFR_W-1:0]        refr_q;
	logic                     spike_q;
	logic [LEAK_W-1:0]        leak_r;
	logic [REFR_W-1:0]        refr_ticks_r;
	logic [STEP_W-1:0]        step_r;
	logic [THR_W-1:0]         floor_r;
	logic [THR_W-1:0]         ceil_r;
	logic [RATE_W-1:0]        target_r;
	logic                     adapts_r;

	neuron_cmd_t  pending_cmds[$];
	neuron_view_t awaited_views[$];
	neuron_view_t want;

	int idle_pct = 0;
	int gap_left = 0;
	int hold_left = 0;
	int beats_sent = 0;
	int views_checked = 0;
	int spikes_seen = 0;
	int mismatches = 0;
	int settings_used = 1;
	int quiet_cycles = 0;

	// Apply one operation to the predicted state and queue the state it leaves
	function automatic void advance_neuron(neuron_cmd_t cmd);
		longint v, t, d, p, lo, hi, stp;
		neuron_view_t view;
		v = volt_q;
		t = thr_q;
		d = drive_q;
		lo = floor_r;
		hi = ceil_r;
		stp = step_r;
		case (cmd.op)
			OP_TICK: begin
				if (refr_q != 0) begin
					refr_q = refr_q - REFR_W'(1);
					spike_q = 1'b0;
				end else if (v >= t) begin
					spike_q = 1'b1;
					if (count_q != COUNT_FULL) count_q = count_q + FCNT_W'(1);
					if (v > 0) d = (DRIVE_FULL - d < v) ? DRIVE_FULL : d + v;
					v = (v > t) ? v - t : 0;
					refr_q = refr_ticks_r;
				end else begin
					// decay, floor rounding via arithmetic shift
					spike_q = 1'b0;
					p = v * longint'(leak_r);
					v = p >>> LEAK_SHIFT;
				end
			end
			OP_PULSE: begin
				v = v + cmd.amount;
				if (v > VOLT_MAX) v = VOLT_MAX;
				if (v < VOLT_MIN) v = VOLT_MIN;
			end
			OP_SET_VOLT: v = cmd.amount;
			OP_MARK_FIRE: begin
				spike_q = 1'b1;
				if (count_q != COUNT_FULL) count_q = count_q + FCNT_W'(1);
			end
			OP_ADAPT: begin
				// step toward target, floor first so the ceiling wins
				if (adapts_r) begin
					if (count_q > target_r) t = t + stp;
					else if (count_q < target_r) t = t - stp;
					if (t < lo) t = lo;
					if (t > hi) t = hi;
				end
			end
			OP_CLR_COUNT: count_q = '0;
			OP_RESET: begin
				v = 0;
				d = 0;
				spike_q = 1'b0;
				refr_q = '0;
			end
			default: ;
		endcase
		volt_q = v[VOLT_W-1:0];
		thr_q = t[THR_W-1:0];
		drive_q = d[DRIVE_W-1:0];
		view.spike = spike_q;
		view.volt = volt_q;
		view.thr = thr_q;
		view.count = count_q;
		view.drive = drive_q;
		awaited_views.insert(awaited_views.size(), view);
	endfunction

	function automatic op_t pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) return OP_TICK;
		if (r < 60) return OP_PULSE;
		if (r < 67) return OP_SET_VOLT;
		if (r < 72) return OP_MARK_FIRE;
		if (r < 82) return OP_ADAPT;
		if (r < 88) return OP_CLR_COUNT;
		if (r < 95) return OP_RESET;
		return op_t'(OP_SPARE_CODE);
	endfunction

	// Mostly amounts on the scale of the threshold so that spikes happen
	function automatic logic signed [VOLT_W-1:0] pick_amount();
		int unsigned span;
		logic signed [VOLT_W-1:0] a;
		span = 32'(thr_q >> 1) + 1;
		case ($urandom_range(0, 9))
			0: a = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			1, 2: a = $urandom();
			default: begin
				a = $urandom_range(0, span);
				if ($urandom_range(0, 4) == 0) a = -a;
			end
		endcase
		return a;
	endfunction

	task automatic queue_op(op_t op, logic signed [VOLT_W-1:0] amount);
		neuron_cmd_t cmd;
		cmd.op = op;
		cmd.amount = amount;
		wait (pending_cmds.size() < QUEUE_AHEAD);
		pending_cmds.insert(pending_cmds.size(), cmd);
	endtask

	task automatic settle();
		wait (pending_cmds.size() == 0 && awaited_views.size() == 0 && !item_ch.valid);
		@(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_LEAK_FACTOR: leak_r = val[LEAK_W-1:0];
			REG_REFR_TICKS:  refr_ticks_r = val[REFR_W-1:0];
			REG_THR_STEP:    step_r = val[STEP_W-1:0];
			REG_THR_FLOOR:   floor_r = val[THR_W-1:0];
			REG_THR_CEILING: ceil_r = val[THR_W-1:0];
			REG_INIT_THR: begin
				// also reloads the live threshold
				thr_q = val[THR_W-1:0];
			end
			REG_TARGET_RATE: target_r = val[RATE_W-1:0];
			REG_ADAPTS:      adapts_r = val[0];
			default: ;
		endcase
	endtask

	task automatic run_random(int n);
		repeat (n) queue_op(pick_op(), pick_amount());
		settle();
	endtask

	task automatic flag_mismatch(string field, logic [63:0] got, logic [63:0] exp_val);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t: result %0d %s got %0h, expected %0h", $realtime, views_checked,
				field, got, exp_val);
	endtask

	// Driver: presents queued operations, holds each beat until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				advance_neuron(pending_cmds.pop_front());
				beats_sent++;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					item_ch.valid <= 1'b0;
				end else if (pending_cmds.size() == 0) begin
					item_ch.valid <= 1'b0;
				end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
					gap_left = $urandom_range(0, 3);
					item_ch.valid <= 1'b0;
				end else begin
					item_ch.valid <= 1'b1;
					item_ch.operation <= pending_cmds[0].op;
					item_ch.amount <= pending_cmds[0].amount;
				end
			end
		end
	end

	// Monitor: checks each result beat against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				views_checked++;
				if (awaited_views.size() == 0) begin
					flag_mismatch("with nothing awaited", 64'd1, 64'd0);
				end else begin
					want = awaited_views.pop_front();
					if (result_ch.spike !== want.spike)
						flag_mismatch("spike", result_ch.spike, want.spike);
					if (result_ch.voltage_out !== want.volt)
						flag_mismatch("voltage_out", result_ch.voltage_out, want.volt);
					if (result_ch.threshold_out !== want.thr)
						flag_mismatch("threshold_out", result_ch.threshold_out, want.thr);
					if (result_ch.fire_count_out !== want.count)
						flag_mismatch("fire_count_out", result_ch.fire_count_out, want.count);
					if (result_ch.drive_out !== want.drive)
						flag_mismatch("drive_out", result_ch.drive_out, want.drive);
					if (want.spike) spikes_seen++;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				hold_left = $urandom_range(0, 3);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("leaky_integrate_fire_neuron_test failed");
		$finish;
	end

	initial begin
		item_ch.valid = 1'b0;
		item_ch.operation = OP_TICK;
		item_ch.amount = '0;
		result_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_LEAK_FACTOR;
		cfg_data = '0;
		arst_n = 1'b0;

		// predicted state after reset
		leak_r = LEAK_RST;
		refr_ticks_r = REFR_RST;
		step_r = STEP_RST;
		floor_r = FLOOR_RST;
		ceil_r = CEILING_RST;
		target_r = RATE_RST;
		adapts_r = 1'b1;
		volt_q = '0;
		thr_q = INIT_THR_RST;
		count_q = '0;
		drive_q = '0;
		refr_q = '0;
		spike_q = 1'b0;

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed: saturation, spike and refractory, leak rounding, every operation
		idle_pct = 25;
		queue_op(OP_TICK, '0);
		queue_op(OP_SET_VOLT, 32'sh7FFF_FFFF);
		queue_op(OP_PULSE, 32'sd1);
		queue_op(OP_TICK, '0);
		queue_op(OP_TICK, '0);
		queue_op(OP_TICK, '0);
		queue_op(OP_TICK, '0);
		queue_op(OP_RESET, 32'sh5A5A_A5A5);
		queue_op(OP_SET_VOLT, 32'sh8000_0000);
		queue_op(OP_PULSE, -32'sd1);
		queue_op(OP_TICK, '0);
		queue_op(OP_SET_VOLT, -32'sd1);
		queue_op(OP_TICK, '0);
		queue_op(OP_SET_VOLT, 32'sd3);
		queue_op(OP_TICK, '0);
		queue_op(OP_SET_VOLT, 32'sd65536);
		queue_op(OP_TICK, '0);
		queue_op(OP_MARK_FIRE, '0);
		queue_op(OP_ADAPT, '0);
		queue_op(OP_CLR_COUNT, '0);
		queue_op(OP_ADAPT, '0);
		queue_op(op_t'(OP_SPARE_CODE), 32'sh7FFF_FFFF);
		queue_op(OP_PULSE, 32'sh7FFF_FFFF);
		queue_op(OP_RESET, '0);
		run_random(350);

		// Low extremes, no idling: zero threshold, no leak, no refractory, target zero
		idle_pct = 0;
		write_reg(REG_LEAK_FACTOR, 31'd0);
		write_reg(REG_REFR_TICKS, 31'd0);
		write_reg(REG_THR_STEP, 31'd65535);
		write_reg(REG_THR_FLOOR, 31'd0);
		write_reg(REG_THR_CEILING, 31'h7FFF_FFFF);
		write_reg(REG_INIT_THR, 31'd0);
		write_reg(REG_TARGET_RATE, 31'd0);
		write_reg(REG_ADAPTS, 31'd1);
		settings_used++;
		run_random(250);

		// High extremes with adaptation off
		idle_pct = 40;
		write_reg(REG_LEAK_FACTOR, 31'd65535);
		write_reg(REG_REFR_TICKS, 31'd255);
		write_reg(REG_THR_STEP, 31'd0);
		write_reg(REG_THR_FLOOR, 31'h7FFF_FFFF);
		write_reg(REG_INIT_THR, 31'h7FFF_FFFF);
		write_reg(REG_TARGET_RATE, 31'd65535);
		write_reg(REG_ADAPTS, 31'd0);
		settings_used++;
		run_random(250);

		// Floor above ceiling: adaptation lands on the ceiling
		idle_pct = 25;
		write_reg(REG_LEAK_FACTOR, 31'd32768);
		write_reg(REG_REFR_TICKS, 31'd1);
		write_reg(REG_THR_STEP, 31'd655);
		write_reg(REG_THR_FLOOR, 31'd1000000);
		write_reg(REG_THR_CEILING, 31'd50000);
		write_reg(REG_INIT_THR, 31'd100000);
		write_reg(REG_TARGET_RATE, 31'd3);
		write_reg(REG_ADAPTS, 31'd1);
		settings_used++;
		run_random(250);

		// Ordinary random settings
		repeat (2) begin
			idle_pct = 15;
			write_reg(REG_LEAK_FACTOR, CFG_W'($urandom_range(40000, 65535)));
			write_reg(REG_REFR_TICKS, CFG_W'($urandom_range(0, 4)));
			write_reg(REG_THR_STEP, CFG_W'($urandom_range(0, 8000)));
			write_reg(REG_THR_FLOOR, CFG_W'($urandom_range(0, 65536)));
			write_reg(REG_THR_CEILING, CFG_W'($urandom_range(32768, 2000000)));
			write_reg(REG_INIT_THR, CFG_W'($urandom_range(1000, 500000)));
			write_reg(REG_TARGET_RATE, CFG_W'($urandom_range(0, 8)));
			write_reg(REG_ADAPTS, CFG_W'($urandom_range(0, 1)));
			settings_used++;
			run_random(200);
		end

		// Zero threshold at full-scale voltage, no idling: a spike on every tick
		idle_pct = 0;
		write_reg(REG_REFR_TICKS, 31'd0);
		write_reg(REG_THR_FLOOR, 31'd0);
		write_reg(REG_INIT_THR, 31'd0);
		write_reg(REG_ADAPTS, 31'd0);
		settings_used++;
		queue_op(OP_CLR_COUNT, '0);
		queue_op(OP_RESET, '0);
		queue_op(OP_SET_VOLT, 32'sh7FFF_FFFF);
		repeat (FIRE_TICKS) queue_op(OP_TICK, '0);
		queue_op(OP_MARK_FIRE, '0);
		queue_op(OP_PULSE, 32'sh7FFF_FFFF);
		queue_op(OP_TICK, '0);
		queue_op(OP_ADAPT, '0);
		queue_op(OP_CLR_COUNT, '0);
		queue_op(OP_RESET, '0);
		settle();
		repeat (4) @(posedge clk);

		$display("%0d operation beats over %0d register settings, %0d results checked, %0d spikes",
			beats_sent, settings_used, views_checked, spikes_seen);
		$display("covered pulse saturation, leak rounding, refractory spiking and threshold clamps");
		if (mismatches == 0)
			$display("leaky_integrate_fire_neuron_test passed");
		else
			$display("leaky_integrate_fire_neuron_test failed");
		$finish;
	end

endmodule

`default_nettype wire
